// File: design/slcsz_pkg.sv
package slcsz_pkg;

   localparam int COEFF_WIDTH   = 18;
   localparam int COUNT_WIDTH   = 24;
   localparam int BYTE_WIDTH    = 22;
   localparam int SCALER_WIDTH  = 8;
   localparam int LEN_WIDTH     = 6;
   localparam int MSB_WIDTH     = $clog2(COEFF_WIDTH);
   localparam int DIV_CNT_WIDTH = $clog2(BYTE_WIDTH);

   typedef struct packed {
      logic signed [COEFF_WIDTH-1:0] coefficient;
      logic                          last_in_slice;
   } req_data_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] trimmed_bits;
      logic [BYTE_WIDTH-1:0]  padded_bytes;
      logic [BYTE_WIDTH-1:0]  length_units;
      logic                   count_saturated;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_CLOSE,
      ST_LOAD,
      ST_DIVIDE,
      ST_PUBLISH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic load_div;
      logic step_div;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
   } ctrl_status_type;

endpackage

// File: design/slcsz_div.sv
module slcsz_div
   import slcsz_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    step,
   input  logic [BYTE_WIDTH-1:0]   dividend,
   input  logic [SCALER_WIDTH-1:0] divisor,
   output logic [BYTE_WIDTH-1:0]   quotient,
   output logic [SCALER_WIDTH-1:0] divisor_held,
   output logic                    last_step
);

   logic [BYTE_WIDTH-1:0]    acc_ff, acc_in;
   logic [SCALER_WIDTH-1:0]  rem_ff, rem_in;
   logic [SCALER_WIDTH-1:0]  den_ff, den_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [SCALER_WIDTH:0]    shifted;
   logic [SCALER_WIDTH+1:0]  diff;

   // one restoring step per cycle while step is high
   always_comb begin
      shifted = {rem_ff, acc_ff[BYTE_WIDTH-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         acc_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = '0;
      end else if (step) begin
         if (!diff[SCALER_WIDTH+1]) begin
            rem_in = diff[SCALER_WIDTH-1:0];
            acc_in = {acc_ff[BYTE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[SCALER_WIDTH-1:0];
            acc_in = {acc_ff[BYTE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign quotient     = acc_ff;
   assign divisor_held = den_ff;
   assign last_step    = (cnt_ff == DIV_CNT_WIDTH'(BYTE_WIDTH - 1));

endmodule

// File: design/slcsz_dp.sv
module slcsz_dp
   import slcsz_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [SCALER_WIDTH-1:0] csr_wdata,
   input  req_data_type            req_data,
   input  ctrl_cmd_type            cmd,
   output ctrl_status_type         status,
   output rsp_data_type            rsp_data
);

   logic [SCALER_WIDTH-1:0] scaler_ff;
   logic [SCALER_WIDTH-1:0] scaler_eff;

   logic [COEFF_WIDTH-1:0] raw;
   logic [COEFF_WIDTH-1:0] mag;
   logic [COEFF_WIDTH-1:0] mag_p1;
   logic [MSB_WIDTH-1:0]   msb;
   logic [LEN_WIDTH-1:0]   len_in;

   logic                 st_valid_ff;
   logic [LEN_WIDTH-1:0] len_ff;
   logic                 nz_ff;
   logic                 last_ff;

   logic [COUNT_WIDTH-1:0] gross_ff, gross_in;
   logic [COUNT_WIDTH-1:0] btln_ff, btln_in;
   logic                   sat_ff, sat_in;
   logic [COUNT_WIDTH:0]   sum;
   logic [COUNT_WIDTH-1:0] sum_sat;
   logic                   ovf;

   logic [COUNT_WIDTH-1:0] trimmed_ff, trimmed_in;
   logic                   slice_sat_ff, slice_sat_in;

   logic [COUNT_WIDTH:0]   bits_p7;
   logic [BYTE_WIDTH-1:0]  dividend;
   logic [BYTE_WIDTH-1:0]  quotient;
   logic [SCALER_WIDTH-1:0] den;
   logic [BYTE_WIDTH+SCALER_WIDTH-1:0] product;

   rsp_data_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scaler_ff <= SCALER_WIDTH'(1);
      end else if (csr_valid) begin
         scaler_ff <= csr_wdata;
      end
   end

   assign scaler_eff = (scaler_ff == '0) ? SCALER_WIDTH'(1) : scaler_ff;

   // code length of the incoming coefficient
   always_comb begin
      raw    = req_data.coefficient;
      mag    = raw[COEFF_WIDTH-1] ? (~raw + COEFF_WIDTH'(1)) : raw;
      mag_p1 = mag + COEFF_WIDTH'(1);
      msb    = '0;
      for (int i = 0; i < COEFF_WIDTH; i++) begin
         if (mag_p1[i]) begin
            msb = MSB_WIDTH'(i);
         end
      end
      len_in = LEN_WIDTH'({msb, 1'b1}) + LEN_WIDTH'(mag != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= cmd.accept;
      end
      if (cmd.accept) begin
         len_ff  <= len_in;
         nz_ff   <= (mag != '0);
         last_ff <= req_data.last_in_slice;
      end
   end

   // saturating accumulation
   always_comb begin
      sum          = {1'b0, gross_ff} + (COUNT_WIDTH + 1)'(len_ff);
      ovf          = sum[COUNT_WIDTH];
      sum_sat      = ovf ? '1 : sum[COUNT_WIDTH-1:0];
      gross_in     = gross_ff;
      btln_in      = btln_ff;
      sat_in       = sat_ff;
      trimmed_in   = trimmed_ff;
      slice_sat_in = slice_sat_ff;
      if (st_valid_ff) begin
         if (last_ff) begin
            trimmed_in   = nz_ff ? sum_sat : btln_ff;
            slice_sat_in = sat_ff | ovf;
            gross_in     = '0;
            btln_in      = '0;
            sat_in       = 1'b0;
         end else begin
            gross_in = sum_sat;
            btln_in  = nz_ff ? sum_sat : btln_ff;
            sat_in   = sat_ff | ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      trimmed_ff   <= trimmed_in;
      slice_sat_ff <= slice_sat_in;
      if (reset) begin
         gross_ff <= '0;
         btln_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         gross_ff <= gross_in;
         btln_ff  <= btln_in;
         sat_ff   <= sat_in;
      end
   end

   // bytes rounded up, then biased for a rounded-up division
   always_comb begin
      bits_p7  = {1'b0, trimmed_ff} + (COUNT_WIDTH + 1)'(7);
      dividend = bits_p7[COUNT_WIDTH:3] + BYTE_WIDTH'(scaler_eff) - BYTE_WIDTH'(1);
   end

   slcsz_div u_div (
      .clock        (clock),
      .reset        (reset),
      .load         (cmd.load_div),
      .step         (cmd.step_div),
      .dividend     (dividend),
      .divisor      (scaler_eff),
      .quotient     (quotient),
      .divisor_held (den),
      .last_step    (status.div_last)
   );

   assign product = (BYTE_WIDTH + SCALER_WIDTH)'(quotient) *
                    (BYTE_WIDTH + SCALER_WIDTH)'(den);

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff.trimmed_bits    <= trimmed_ff;
         rsp_data_ff.padded_bytes    <= product[BYTE_WIDTH-1:0];
         rsp_data_ff.length_units    <= quotient;
         rsp_data_ff.count_saturated <= slice_sat_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// File: design/slcsz_ctrl.sv
module slcsz_ctrl
   import slcsz_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_ready,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step_div = 1'b1;
            if (status.div_last) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/slice_coefficient_size_counter.sv
// slice coefficient size counter
// req channel: one quantised coefficient per transfer, in coded order, with
//   last_in_slice marking the final coefficient of a slice component
// rsp channel: one result per slice: trimmed bit count, bytes padded to a
//   multiple of the scaler, length in scaler units, saturation flag
// csr channel: writes slice_size_scaler (zero acts as one); always ready,
//   write only while no slice is in flight
// throughput: one coefficient per cycle inside a slice; after the last
//   coefficient req_ready drops through the close state, the load state,
//   the bit-serial divide and the publish state
// rsp_valid rises once publish writes the output register, which waits
//   until that register is free
// a stalled receiver holds the result in the output register; coefficients
//   of the next slice are still taken, and its end waits in publish until the
//   register is free
// reset clears the counters, drops rsp_valid and sets the scaler to one
module slice_coefficient_size_counter
   import slcsz_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_data_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_data_type            rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [SCALER_WIDTH-1:0] csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   slcsz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_in_slice),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   slcsz_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/slcsz_checker.sv
module slcsz_checker
   import slcsz_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input req_data_type            req_data,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input rsp_data_type            rsp_data,
   input logic                    csr_valid,
   input logic                    csr_ready,
   input logic [SCALER_WIDTH-1:0] csr_wdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // end of slice closes the input for the divide
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_in_slice |=> !req_ready)
      else $error("req_ready high right after last transfer");

   // empty slice gives zero length
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trimmed_bits == '0 |->
         rsp_data.length_units == '0 && rsp_data.padded_bytes == '0)
      else $error("nonzero length for empty slice");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // configuration port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr transfer stalled");

endmodule

bind slice_coefficient_size_counter slcsz_checker u_slcsz_checker (.*);
